// File: design/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, constants and the microcode ROM of the prime factorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pf_pkg;

    localparam int STEP_W      = 4;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 5;
    localparam int FIELD_W     = 32;

    // Datapath operations, one per control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_EMIT_Z,
        OP_EMIT_N,
        OP_EMIT_EMPTY,
        OP_INC_Z
    } op_t;

    // Jump conditions: jump to target when true, otherwise fall through
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_IN,
        C_N_LE1,
        C_CNT_MAX,
        C_DIV_BUSY,
        C_Z_GT_Q,
        C_REM_NZ,
        C_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic n_le1;
        logic cnt_max;
        logic div_busy;
        logic z_gt_q;
        logic rem_nz;
        logic out_blocked;
    } status_t;

    // Program steps
    localparam logic [STEP_W-1:0] S_WAIT      = 4'd0;
    localparam logic [STEP_W-1:0] S_SMALL     = 4'd1;
    localparam logic [STEP_W-1:0] S_LOOP      = 4'd2;
    localparam logic [STEP_W-1:0] S_DIV       = 4'd3;
    localparam logic [STEP_W-1:0] S_BOUND     = 4'd4;
    localparam logic [STEP_W-1:0] S_EVEN      = 4'd5;
    localparam logic [STEP_W-1:0] S_EMIT_Z    = 4'd6;
    localparam logic [STEP_W-1:0] S_BACK_Z    = 4'd7;
    localparam logic [STEP_W-1:0] S_FINAL     = 4'd8;
    localparam logic [STEP_W-1:0] S_EMIT_N    = 4'd9;
    localparam logic [STEP_W-1:0] S_DONE_N    = 4'd10;
    localparam logic [STEP_W-1:0] S_EMPTY     = 4'd11;
    localparam logic [STEP_W-1:0] S_DONE_E    = 4'd12;
    localparam logic [STEP_W-1:0] S_INC       = 4'd13;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            S_WAIT:   w = '{OP_LOAD,       C_NO_IN,       S_WAIT};
            S_SMALL:  w = '{OP_NOP,        C_N_LE1,       S_EMPTY};
            S_LOOP:   w = '{OP_DIV_START,  C_CNT_MAX,     S_FINAL};
            S_DIV:    w = '{OP_DIV_STEP,   C_DIV_BUSY,    S_DIV};
            S_BOUND:  w = '{OP_NOP,        C_Z_GT_Q,      S_FINAL};
            S_EVEN:   w = '{OP_NOP,        C_REM_NZ,      S_INC};
            S_EMIT_Z: w = '{OP_EMIT_Z,     C_OUT_BLOCKED, S_EMIT_Z};
            S_BACK_Z: w = '{OP_NOP,        C_ALWAYS,      S_LOOP};
            S_FINAL:  w = '{OP_NOP,        C_N_LE1,       S_WAIT};
            S_EMIT_N: w = '{OP_EMIT_N,     C_OUT_BLOCKED, S_EMIT_N};
            S_DONE_N: w = '{OP_NOP,        C_ALWAYS,      S_WAIT};
            S_EMPTY:  w = '{OP_EMIT_EMPTY, C_OUT_BLOCKED, S_EMPTY};
            S_DONE_E: w = '{OP_NOP,        C_ALWAYS,      S_WAIT};
            S_INC:    w = '{OP_INC_Z,      C_ALWAYS,      S_LOOP};
            default:  w = '{OP_NOP,        C_ALWAYS,      S_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/pf_divider.sv
// ----------------------------------------------------------------------------
// pf_divider
// Restoring divider, one quotient bit per cycle while step is asserted.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_divider #(
    parameter int VW = 32,
    parameter int DW = 17
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          step,
    input  wire logic [VW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic      [VW-1:0] quotient,
    output logic      [DW-1:0] remainder,
    output logic               busy
);

    localparam int CW = $clog2(VW + 1);

    logic [VW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[VW-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CW'(VW);
        end
        else if (step)
        begin
            quo_next = {quo_reg[VW-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // the step taken with one count left is the final one
    assign busy      = (cnt_reg != CW'(1));
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: design/pf_datapath.sv
// ----------------------------------------------------------------------------
// pf_datapath
// Remainder, trial divisor, item count, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_datapath #(
    parameter int VW = 32,
    parameter int DW = 17
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pf_pkg::ctrl_t         ctrl,
    output pf_pkg::status_t            status,
    input  wire logic                  in_valid,
    input  wire logic [31:0]           number,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [31:0]                factor,
    output logic                       last_factor,
    output logic                       no_factors
);

    logic [VW-1:0]             n_reg, n_next;
    logic [DW-1:0]             z_reg, z_next;
    logic [pf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [31:0]               factor_reg, factor_next;
    logic                      last_reg, last_next;
    logic                      none_reg, none_next;

    logic [63:0]   number_wide;
    logic [63:0]   n_wide;
    logic [63:0]   z_wide;
    logic [VW-1:0] n_load;
    logic [VW-1:0] quotient;
    logic [DW-1:0] remainder;
    logic          div_busy;
    logic          out_free;
    logic          emit;

    pf_divider #(
        .VW (VW),
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.op == pf_pkg::OP_DIV_START),
        .step      (ctrl.op == pf_pkg::OP_DIV_STEP),
        .dividend  (n_reg),
        .divisor   (z_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .busy      (div_busy)
    );

    assign number_wide = 64'(number);
    assign n_load      = number_wide[VW-1:0];
    assign n_wide      = 64'(n_reg);
    assign z_wide      = 64'(z_reg);
    assign out_free    = !out_valid_reg || out_ready;
    assign emit        = out_free && (ctrl.op == pf_pkg::OP_EMIT_Z ||
                                      ctrl.op == pf_pkg::OP_EMIT_N ||
                                      ctrl.op == pf_pkg::OP_EMIT_EMPTY);

    always_comb
    begin
        n_next         = n_reg;
        z_next         = z_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        factor_next    = factor_reg;
        last_next      = last_reg;
        none_next      = none_reg;
        case (ctrl.op)
            pf_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    n_next   = n_load;
                    z_next   = DW'(2);
                    cnt_next = '0;
                end
            end
            pf_pkg::OP_INC_Z:
            begin
                z_next = z_reg + DW'(1);
            end
            pf_pkg::OP_EMIT_Z:
            begin
                if (out_free)
                begin
                    // divide the factor out; a unit quotient ends the list
                    n_next      = quotient;
                    cnt_next    = cnt_reg + pf_pkg::CNT_W'(1);
                    factor_next = z_wide[31:0];
                    last_next   = (quotient == VW'(1));
                    none_next   = 1'b0;
                end
            end
            pf_pkg::OP_EMIT_N:
            begin
                if (out_free)
                begin
                    factor_next = n_wide[31:0];
                    last_next   = 1'b1;
                    none_next   = 1'b0;
                end
            end
            pf_pkg::OP_EMIT_EMPTY:
            begin
                if (out_free)
                begin
                    factor_next = '0;
                    last_next   = 1'b1;
                    none_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            z_reg         <= DW'(2);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            z_reg         <= z_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg <= factor_next;
        last_reg   <= last_next;
        none_reg   <= none_next;
    end

    always_comb
    begin
        status.in_valid    = in_valid;
        status.n_le1       = (n_reg <= VW'(1));
        status.cnt_max     = (cnt_reg == pf_pkg::CNT_W'(pf_pkg::MAX_RESULTS - 1));
        status.div_busy    = div_busy;
        status.z_gt_q      = (VW'(z_reg) > quotient);
        status.rem_nz      = (remainder != '0);
        status.out_blocked = !out_free;
    end

    assign out_valid   = out_valid_reg;
    assign factor      = factor_reg;
    assign last_factor = last_reg;
    assign no_factors  = none_reg;

endmodule

`default_nettype wire

// File: design/pf_sequencer.sv
// ----------------------------------------------------------------------------
// pf_sequencer
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pf_pkg::status_t status,
    output pf_pkg::ctrl_t        ctrl
);

    logic [pf_pkg::STEP_W-1:0] pc_reg, pc_next;
    pf_pkg::ucode_t            word;
    logic                      take;

    assign word = pf_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        case (word.cond)
            pf_pkg::C_ALWAYS:      take = 1'b1;
            pf_pkg::C_NO_IN:       take = !status.in_valid;
            pf_pkg::C_N_LE1:       take = status.n_le1;
            pf_pkg::C_CNT_MAX:     take = status.cnt_max;
            pf_pkg::C_DIV_BUSY:    take = status.div_busy;
            pf_pkg::C_Z_GT_Q:      take = status.z_gt_q;
            pf_pkg::C_REM_NZ:      take = status.rem_nz;
            pf_pkg::C_OUT_BLOCKED: take = status.out_blocked;
            default:               take = 1'b1;
        endcase
        pc_next = take ? word.target : pc_reg + pf_pkg::STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= pf_pkg::S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op = word.op;

endmodule

`default_nettype wire

// File: design/prime_factorizer_top.sv
// ----------------------------------------------------------------------------
// prime_factorizer_top
// Trial-division prime factorization, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_ready  | number
//  output  | out       | out_valid / out_ready| factor, last_factor, no_factors
//
//  Each trial division runs the serial restoring divider, one quotient bit a
//  cycle; a trial that finds a factor also emits it.
//  A 32-bit prime needs about 65535 trials per transaction.
//  One transaction is worked on at a time; in_ready is high only when waiting.
//  A stalled output holds the sequencer on its emit step. Reset is immediate.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_factorizer_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      factor,
    output logic             last_factor,
    output logic             no_factors
);

    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;

    pf_pkg::ctrl_t   ctrl;
    pf_pkg::status_t status;

    pf_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    pf_datapath #(
        .VW (VALUE_WIDTH),
        .DW (DW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_valid    (in_valid),
        .number      (number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .factor      (factor),
        .last_factor (last_factor),
        .no_factors  (no_factors)
    );

    assign in_ready = (ctrl.op == pf_pkg::OP_LOAD);

endmodule

`default_nettype wire

// File: tb/prime_factorizer_top_test.sv
// ----------------------------------------------------------------------------
// prime_factorizer_top_test
// Self-checking bench for the trial-division prime factorizer. Numbers go in
// on the input channel; every factor transaction that comes out is compared
// against a factor list computed here by trial division, in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_factorizer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] factor;
        logic        last_factor;
        logic        no_factors;
    } factor_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] number;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] factor;
    logic        last_factor;
    logic        no_factors;

    factor_item_t expected_factors[$];

    int numbers_sent;
    int factors_checked;
    int mismatches;
    int hold_out_cycles;
    bit no_idle;

    prime_factorizer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .number      (number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .factor      (factor),
        .last_factor (last_factor),
        .no_factors  (no_factors)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Append one expected transaction at the tail of the pending queue
    function automatic void add_expected(input factor_item_t item);
        expected_factors.insert(expected_factors.size(), item);
    endfunction

    // Expected factor list of one number, appended to the pending queue
    function automatic void predict_factors(input logic [31:0] value);
        logic [31:0]  rest;
        logic [31:0]  trial;
        logic [31:0]  found[pf_pkg::MAX_RESULTS];
        int           count;
        factor_item_t item;
        rest  = value;
        trial = 32'd2;
        count = 0;
        if (rest <= 32'd1)
        begin
            item.factor      = 32'd0;
            item.last_factor = 1'b1;
            item.no_factors  = 1'b1;
            add_expected(item);
            return;
        end
        while (trial <= rest / trial)
        begin
            if (count == pf_pkg::MAX_RESULTS - 1)
                break;
            if (rest % trial == 0)
            begin
                found[count] = trial;
                count++;
                rest = rest / trial;
            end
            else
            begin
                trial++;
            end
        end
        if (rest > 32'd1)
        begin
            found[count] = rest;
            count++;
        end
        for (int k = 0; k < count; k++)
        begin
            item.factor      = found[k];
            item.last_factor = (k == count - 1);
            item.no_factors  = 1'b0;
            add_expected(item);
        end
    endfunction

    function automatic int idle_cycles();
        int n;
        n = 0;
        while (!no_idle && $urandom_range(0, 99) < 33)
            n++;
        return n;
    endfunction

    // Small-prime products over a bounded cofactor keep the trial loop short
    function automatic logic [31:0] random_number();
        int unsigned     primes[15];
        longint unsigned v;
        int unsigned     p;
        int              kind;
        primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
        kind = $urandom_range(0, 99);
        if (kind < 5)
            return $urandom_range(0, 15);
        if (kind < 10)
            return $urandom_range(0, 262143);
        if (kind < 40)
            v = 64'($urandom_range(1, 255));
        else
            v = 64'($urandom_range(1, 65535));
        forever
        begin
            p = primes[$urandom_range(0, 14)];
            if (v * p > 64'hFFFF_FFFF)
                break;
            v = v * p;
            if ($urandom_range(0, 99) < 8)
                break;
        end
        return v[31:0];
    endfunction

    task automatic send_number(input logic [31:0] value);
        int gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        do
            @(posedge clk);
        while (!in_ready);
        predict_factors(value);
        numbers_sent++;
    endtask

    // Hold the input channel quiet until every pending factor has arrived
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_factors.size() == 0);
    endtask

    task automatic test_special_values();
        logic [31:0] values[8];
        values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd49, 32'd65537, 32'd131071};
        foreach (values[i])
            send_number(values[i]);
        send_number(32'd524287);
        send_number(32'd1000003);
        drain_results();
    endtask

    task automatic test_wide_values();
        logic [31:0] values[9];
        values = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'hFFFF_0000, 32'd3486784401, 32'd16445771, 32'd8633,
                   32'd360};
        foreach (values[i])
            send_number(values[i]);
        drain_results();
    endtask

    // Block the output long enough that the factorizer stalls its input
    task automatic test_output_backpressure();
        hold_out_cycles = 3000;
        send_number(32'd12);
        send_number(32'hFFFF_0000);
        send_number(32'd0);
        send_number(32'd97);
        drain_results();
    endtask

    task automatic test_random_numbers();
        for (int i = 0; i < 78; i++)
        begin
            no_idle = (i >= 30 && i < 55);
            send_number(random_number());
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    // Output side: random stalls, plus an occasional long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_out_cycles - 1) @(negedge clk);
                hold_out_cycles = 0;
            end
            else
            begin
                out_ready <= no_idle || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge clk)
    begin : check_factor
        factor_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            factors_checked++;
            if (expected_factors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected transaction factor=%0d last=%0b none=%0b",
                             $realtime, factor, last_factor, no_factors);
            end
            else
            begin
                want = expected_factors.pop_front();
                if (factor !== want.factor || last_factor !== want.last_factor ||
                    no_factors !== want.no_factors)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: mismatch expected factor=%0d last=%0b none=%0b",
                                 $realtime, want.factor, want.last_factor,
                                 want.no_factors);
                        $display("%0t:          actual factor=%0d last=%0b none=%0b",
                                 $realtime, factor, last_factor, no_factors);
                    end
                end
            end
        end
    end

    initial
    begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        number          = 32'd0;
        hold_out_cycles = 0;
        no_idle         = 1'b0;
        numbers_sent    = 0;
        factors_checked = 0;
        mismatches      = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_values();
        test_wide_values();
        test_output_backpressure();
        test_random_numbers();

        // let any stray transaction show up before the verdict
        repeat (100) @(posedge clk);
        $display("Factored %0d numbers into %0d checked factor transactions.",
                 numbers_sent, factors_checked);
        $display("Covered zero, one, primes, prime powers, all-ones and long output stalls.");
        if (mismatches == 0 && expected_factors.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
design/pf_pkg.sv
design/pf_divider.sv
design/pf_datapath.sv
design/pf_sequencer.sv
design/prime_factorizer_top.sv
tb/prime_factorizer_top_test.sv
